// ===== rtl/core/polygon_orientation_classifier_core_macros.svh =====
// Assertion macros for the polygon orientation classifier core.
`ifndef POLYGON_ORIENTATION_CLASSIFIER_CORE_MACROS_SVH
`define POLYGON_ORIENTATION_CLASSIFIER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define POCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define POCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define POCC_ASSERT_SAME(label, ante, cons)
`define POCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/pocc_pkg.sv =====
// Shared types and constants of the polygon orientation classifier core.
package pocc_pkg;

    localparam int COORD_BITS = 24;
    localparam int FIELD_W    = 24;
    localparam int WIDE_W     = 32;
    localparam int PROD_W     = 2 * COORD_BITS;
    localparam int TERM_W     = PROD_W + 1;
    localparam int AREA_W     = 64;

    localparam int QDEPTH     = 4;
    localparam int QIDX_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam int RDEPTH     = 4;
    localparam int RIDX_W     = $clog2(RDEPTH);
    localparam int RCNT_W     = $clog2(RDEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [TERM_W-1:0]     t_term;
    typedef logic signed [AREA_W-1:0]     t_area;

    localparam t_area AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam t_area AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_coord;
        logic signed [FIELD_W-1:0] y_coord;
        logic                      last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [AREA_W-1:0] doubled_area;
        logic                     is_hole;
    } t_result;

    typedef struct packed {
        t_term term_edge;
        t_term term_close;
        logic  first;
        logic  last;
    } t_op;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_opq_stat;

endpackage

// ===== rtl/core/polygon_orientation_classifier_core.sv =====
// Top level of the polygon orientation classifier: shoelace doubled area and hole flag.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   vertex   | push / full        | i_vertex : x_coord, y_coord, last_vertex
//   result   | pop / empty        | o_result : doubled_area, is_hole
//
// One vertex per cycle sustained while full stays low; the back end's 64-bit saturating
// accumulator adds each edge term into its registered running sum.
// A result passes the product registers, term queue, closing stage and result queue.
// Reset is synchronous and clears contour tracking and both queues.
// Vertices keep flowing while results wait, until the four-entry queues fill.
module polygon_orientation_classifier_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  pocc_pkg::t_vertex i_vertex,
    output logic              empty,
    input  logic              pop,
    output pocc_pkg::t_result o_result
);

    logic                q_push;
    logic                q_pop;
    pocc_pkg::t_op       q_wr_op;
    pocc_pkg::t_op       q_rd_op;
    pocc_pkg::t_opq_stat q_stat;

    pocc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_vertex   (i_vertex),
        .i_q_stat   (q_stat),
        .o_op_valid (q_push),
        .o_op       (q_wr_op)
    );

    pocc_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_wr_op),
        .i_pop   (q_pop),
        .o_op    (q_rd_op),
        .o_stat  (q_stat)
    );

    pocc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (q_rd_op),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule

// ===== rtl/core/pocc_front.sv =====
// Front end: takes vertices, tracks the contour, forms both cross-product terms.
module pocc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  pocc_pkg::t_vertex   i_vertex,
    input  pocc_pkg::t_opq_stat i_q_stat,
    output logic                o_op_valid,
    output pocc_pkg::t_op       o_op
);

    function automatic pocc_pkg::t_coord sext_coord(
        input logic signed [pocc_pkg::FIELD_W-1:0] v
    );
        logic [pocc_pkg::WIDE_W-1:0] w;
        w = {{(pocc_pkg::WIDE_W-pocc_pkg::FIELD_W){v[pocc_pkg::FIELD_W-1]}}, v};
        return pocc_pkg::t_coord'(w[pocc_pkg::COORD_BITS-1:0]);
    endfunction

    function automatic pocc_pkg::t_prod mul(
        input pocc_pkg::t_coord a,
        input pocc_pkg::t_coord b
    );
        pocc_pkg::t_prod ea;
        pocc_pkg::t_prod eb;
        ea = pocc_pkg::t_prod'(a);
        eb = pocc_pkg::t_prod'(b);
        return ea * eb;
    endfunction

    logic             accept;
    pocc_pkg::t_coord cur_x;
    pocc_pkg::t_coord cur_y;
    pocc_pkg::t_coord prev_x_eff;
    pocc_pkg::t_coord prev_y_eff;
    pocc_pkg::t_coord first_x_eff;
    pocc_pkg::t_coord first_y_eff;

    pocc_pkg::t_coord r_first_x;
    pocc_pkg::t_coord r_first_y;
    pocc_pkg::t_coord r_prev_x;
    pocc_pkg::t_coord r_prev_y;
    logic             r_in_contour;

    logic             r_v1;
    logic             r_first1;
    logic             r_last1;
    pocc_pkg::t_prod  r_pa;
    pocc_pkg::t_prod  r_pb;
    pocc_pkg::t_prod  r_pc;
    pocc_pkg::t_prod  r_pd;

    logic [pocc_pkg::QCNT_W:0] n_used;

    assign n_used = (pocc_pkg::QCNT_W+1)'(i_q_stat.count) + (pocc_pkg::QCNT_W+1)'(r_v1);
    assign full   = (n_used >= (pocc_pkg::QCNT_W+1)'(pocc_pkg::QDEPTH));
    assign accept = push && !full;

    assign cur_x       = sext_coord(i_vertex.x_coord);
    assign cur_y       = sext_coord(i_vertex.y_coord);
    assign prev_x_eff  = r_in_contour ? r_prev_x  : cur_x;
    assign prev_y_eff  = r_in_contour ? r_prev_y  : cur_y;
    assign first_x_eff = r_in_contour ? r_first_x : cur_x;
    assign first_y_eff = r_in_contour ? r_first_y : cur_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_contour <= 1'b0;
            r_v1         <= 1'b0;
            r_first_x    <= '0;
            r_first_y    <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
        end else begin
            r_v1 <= accept;
            if (accept) begin
                r_prev_x     <= cur_x;
                r_prev_y     <= cur_y;
                r_first_x    <= first_x_eff;
                r_first_y    <= first_y_eff;
                r_in_contour <= !i_vertex.last_vertex;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pa     <= mul(prev_x_eff, cur_y);
            r_pb     <= mul(cur_x, prev_y_eff);
            r_pc     <= mul(cur_x, first_y_eff);
            r_pd     <= mul(first_x_eff, cur_y);
            r_first1 <= !r_in_contour;
            r_last1  <= i_vertex.last_vertex;
        end
    end

    assign o_op_valid       = r_v1;
    assign o_op.term_edge   = pocc_pkg::t_term'(r_pa) - pocc_pkg::t_term'(r_pb);
    assign o_op.term_close  = pocc_pkg::t_term'(r_pc) - pocc_pkg::t_term'(r_pd);
    assign o_op.first       = r_first1;
    assign o_op.last        = r_last1;

endmodule

// ===== rtl/core/pocc_opq.sv =====
// Short queue of cross-product terms between the front and back ends.
`include "polygon_orientation_classifier_core_macros.svh"
module pocc_opq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pocc_pkg::t_op       i_op,
    input  logic                i_pop,
    output pocc_pkg::t_op       o_op,
    output pocc_pkg::t_opq_stat o_stat
);

    pocc_pkg::t_op               r_mem [pocc_pkg::QDEPTH];
    logic [pocc_pkg::QIDX_W-1:0] r_wr;
    logic [pocc_pkg::QIDX_W-1:0] r_rd;
    logic [pocc_pkg::QCNT_W-1:0] r_count;
    logic [pocc_pkg::QIDX_W-1:0] n_wr;
    logic [pocc_pkg::QIDX_W-1:0] n_rd;

    assign n_wr = (r_wr == pocc_pkg::QIDX_W'(pocc_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == pocc_pkg::QIDX_W'(pocc_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    assign o_op         = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);

    `POCC_ASSERT_SAME(a_no_overflow, i_push && !i_pop, r_count < pocc_pkg::QCNT_W'(pocc_pkg::QDEPTH))
    `POCC_ASSERT_SAME(a_no_underflow, i_pop, r_count != '0)

endmodule

// ===== rtl/core/pocc_back.sv =====
// Back end: saturating area accumulation, closing term and result queue.
`include "polygon_orientation_classifier_core_macros.svh"
module pocc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pocc_pkg::t_op       i_op,
    input  pocc_pkg::t_opq_stat i_q_stat,
    output logic                o_q_pop,
    output logic                empty,
    input  logic                pop,
    output pocc_pkg::t_result   o_result
);

    function automatic pocc_pkg::t_area sat_add(
        input pocc_pkg::t_area a,
        input pocc_pkg::t_area b
    );
        logic [pocc_pkg::AREA_W:0] s;
        s = {a[pocc_pkg::AREA_W-1], a} + {b[pocc_pkg::AREA_W-1], b};
        if (s[pocc_pkg::AREA_W] != s[pocc_pkg::AREA_W-1]) begin
            return s[pocc_pkg::AREA_W] ? pocc_pkg::AREA_MIN : pocc_pkg::AREA_MAX;
        end
        return pocc_pkg::t_area'(s[pocc_pkg::AREA_W-1:0]);
    endfunction

    pocc_pkg::t_area             r_sum;
    logic                        r_b1_v;
    pocc_pkg::t_area             r_b1_sum;
    pocc_pkg::t_term             r_b1_tc;
    pocc_pkg::t_area             n_sum;
    pocc_pkg::t_area             n_final;
    pocc_pkg::t_area             base;

    pocc_pkg::t_result           r_mem [pocc_pkg::RDEPTH];
    logic [pocc_pkg::RIDX_W-1:0] r_wr;
    logic [pocc_pkg::RIDX_W-1:0] r_rd;
    logic [pocc_pkg::RCNT_W-1:0] r_count;
    logic [pocc_pkg::RIDX_W-1:0] n_wr;
    logic [pocc_pkg::RIDX_W-1:0] n_rd;
    logic [pocc_pkg::RCNT_W:0]   n_used;
    logic                        res_pop;
    logic                        res_push;

    assign n_used  = (pocc_pkg::RCNT_W+1)'(r_count) + (pocc_pkg::RCNT_W+1)'(r_b1_v);
    assign o_q_pop = !i_q_stat.empty && (n_used < (pocc_pkg::RCNT_W+1)'(pocc_pkg::RDEPTH));

    assign base    = i_op.first ? '0 : r_sum;
    assign n_sum   = sat_add(base, pocc_pkg::t_area'(i_op.term_edge));
    assign n_final = sat_add(r_b1_sum, pocc_pkg::t_area'(r_b1_tc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_b1_v <= 1'b0;
        end else begin
            r_b1_v <= o_q_pop && i_op.last;
            if (o_q_pop) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b1_sum <= n_sum;
            r_b1_tc  <= i_op.term_close;
        end
    end

    assign res_push = r_b1_v;
    assign res_pop  = pop && !empty;
    assign n_wr = (r_wr == pocc_pkg::RIDX_W'(pocc_pkg::RDEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == pocc_pkg::RIDX_W'(pocc_pkg::RDEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (res_push) begin
                r_wr <= n_wr;
            end
            if (res_pop) begin
                r_rd <= n_rd;
            end
            if (res_push && !res_pop) begin
                r_count <= r_count + 1'b1;
            end else if (res_pop && !res_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_mem[r_wr].doubled_area <= n_final;
            r_mem[r_wr].is_hole      <= n_final[pocc_pkg::AREA_W-1];
        end
    end

    assign o_result = r_mem[r_rd];
    assign empty    = (r_count == '0);

    `POCC_ASSERT_SAME(a_res_room, res_push, r_count < pocc_pkg::RCNT_W'(pocc_pkg::RDEPTH))
    `POCC_ASSERT_NEXT(a_close_follows, o_q_pop && i_op.last, r_b1_v)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the polygon orientation classifier core.
`timescale 1ns / 1ps

module tb;

    localparam int CRD_HI     = (1 << (pocc_pkg::COORD_BITS - 1)) - 1;
    localparam int CRD_LO     = -(1 << (pocc_pkg::COORD_BITS - 1));
    localparam int HOLD_LEN   = 200;
    localparam int WIND_LOOPS = 8;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              pop = 1'b0;
    logic              full;
    logic              empty;
    pocc_pkg::t_vertex i_vertex = '0;
    pocc_pkg::t_result o_result;

    polygon_orientation_classifier_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_vertex (i_vertex),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    pocc_pkg::t_result pending_areas[$];
    int                mismatches = 0;

    pocc_pkg::t_coord ctr_first_x = '0;
    pocc_pkg::t_coord ctr_first_y = '0;
    pocc_pkg::t_coord ctr_prev_x = '0;
    pocc_pkg::t_coord ctr_prev_y = '0;
    pocc_pkg::t_area  ctr_sum = '0;
    bit               ctr_open = 1'b0;

    int burst_left = 0;
    bit steady = 1'b0;

    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    logic [15:0] stall_pat = '1;
    int          pat_age = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[polygon_orientation_classifier_core] ERROR");
        $finish;
    end

    function automatic pocc_pkg::t_area cross_of(pocc_pkg::t_coord ax, pocc_pkg::t_coord ay,
                                                 pocc_pkg::t_coord bx, pocc_pkg::t_coord by);
        return pocc_pkg::t_area'(ax) * pocc_pkg::t_area'(by)
             - pocc_pkg::t_area'(bx) * pocc_pkg::t_area'(ay);
    endfunction

    function automatic pocc_pkg::t_area clamp_add(pocc_pkg::t_area a, pocc_pkg::t_area b);
        logic [pocc_pkg::AREA_W:0] s;
        s = {a[pocc_pkg::AREA_W-1], a} + {b[pocc_pkg::AREA_W-1], b};
        if (s[pocc_pkg::AREA_W] != s[pocc_pkg::AREA_W-1]) begin
            return s[pocc_pkg::AREA_W] ? pocc_pkg::AREA_MIN : pocc_pkg::AREA_MAX;
        end
        return pocc_pkg::t_area'(s[pocc_pkg::AREA_W-1:0]);
    endfunction

    function automatic void track_contour(pocc_pkg::t_vertex v);
        pocc_pkg::t_coord  x;
        pocc_pkg::t_coord  y;
        pocc_pkg::t_result r;
        x = v.x_coord[pocc_pkg::COORD_BITS-1:0];
        y = v.y_coord[pocc_pkg::COORD_BITS-1:0];
        if (!ctr_open) begin
            ctr_first_x = x;
            ctr_first_y = y;
            ctr_sum = '0;
            ctr_open = 1'b1;
        end else begin
            ctr_sum = clamp_add(ctr_sum, cross_of(ctr_prev_x, ctr_prev_y, x, y));
        end
        ctr_prev_x = x;
        ctr_prev_y = y;
        if (v.last_vertex) begin
            ctr_sum = clamp_add(ctr_sum, cross_of(x, y, ctr_first_x, ctr_first_y));
            r.doubled_area = ctr_sum;
            r.is_hole = (ctr_sum < 0);
            pending_areas = {pending_areas, r};
            ctr_open = 1'b0;
        end
    endfunction

    function automatic pocc_pkg::t_vertex mk_vertex(int x, int y, bit last);
        pocc_pkg::t_vertex v;
        v = '0;
        v.x_coord = pocc_pkg::FIELD_W'(x);
        v.y_coord = pocc_pkg::FIELD_W'(y);
        v.last_vertex = last;
        return v;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? CRD_HI : CRD_LO;
            1: return int'($urandom_range(0, 64)) - 32;
            2: return int'($urandom_range(0, 8192)) - 4096;
            default: return int'(pocc_pkg::t_coord'($urandom));
        endcase
    endfunction

    // Outside steady mode, wait out a random gap at the start of each burst, then hold the item until taken.
    task automatic send_vertex(input pocc_pkg::t_vertex v);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        push <= 1'b1;
        i_vertex <= v;
        do @(posedge i_clk); while (full);
        track_contour(v);
    endtask

    task automatic end_burst;
        push <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    task automatic test_single_vertex;
        send_vertex(mk_vertex(CRD_HI, CRD_LO, 1'b1));
        send_vertex(mk_vertex(CRD_LO, CRD_LO, 1'b1));
        end_burst();
    endtask

    task automatic test_orientation;
        send_vertex(mk_vertex(0, 0, 1'b0));
        send_vertex(mk_vertex(10, 0, 1'b0));
        send_vertex(mk_vertex(0, 10, 1'b1));
        send_vertex(mk_vertex(0, 0, 1'b0));
        send_vertex(mk_vertex(0, 10, 1'b0));
        send_vertex(mk_vertex(10, 0, 1'b1));
        send_vertex(mk_vertex(1, 1, 1'b0));
        send_vertex(mk_vertex(2, 2, 1'b0));
        send_vertex(mk_vertex(3, 3, 1'b1));
        send_vertex(mk_vertex(5, 7, 1'b0));
        send_vertex(mk_vertex(-3, 2, 1'b1));
        end_burst();
    endtask

    task automatic test_extreme_squares;
        send_vertex(mk_vertex(CRD_LO, CRD_LO, 1'b0));
        send_vertex(mk_vertex(CRD_HI, CRD_LO, 1'b0));
        send_vertex(mk_vertex(CRD_HI, CRD_HI, 1'b0));
        send_vertex(mk_vertex(CRD_LO, CRD_HI, 1'b1));
        send_vertex(mk_vertex(CRD_LO, CRD_LO, 1'b0));
        send_vertex(mk_vertex(CRD_LO, CRD_HI, 1'b0));
        send_vertex(mk_vertex(CRD_HI, CRD_HI, 1'b0));
        send_vertex(mk_vertex(CRD_HI, CRD_LO, 1'b1));
        end_burst();
    endtask

    // Wind around the extreme square several times, then back off a few turns, in each direction in turn.
    task automatic test_long_winding;
        int cx[4];
        int cy[4];
        bit ccw;
        cx = '{CRD_LO, CRD_HI, CRD_HI, CRD_LO};
        cy = '{CRD_LO, CRD_LO, CRD_HI, CRD_HI};
        steady = 1'b1;
        for (int dir = 0; dir < 2; dir++) begin
            ccw = (dir == 0);
            for (int n = 0; n < WIND_LOOPS; n++) begin
                for (int k = 0; k < 4; k++) begin
                    send_vertex(mk_vertex(cx[ccw ? k : 3 - k], cy[ccw ? k : 3 - k], 1'b0));
                end
            end
            for (int n = 0; n < 3; n++) begin
                for (int k = 0; k < 4; k++) begin
                    send_vertex(mk_vertex(cx[ccw ? 3 - k : k], cy[ccw ? 3 - k : k], 1'b0));
                end
            end
            send_vertex(mk_vertex(cx[0], cy[0], 1'b1));
        end
        steady = 1'b0;
        end_burst();
    endtask

    task automatic test_backpressure;
        hold_req <= 1'b1;
        steady = 1'b1;
        for (int n = 0; n < 30; n++) begin
            send_vertex(mk_vertex(rand_coord(), rand_coord(), 1'b1));
        end
        for (int n = 0; n < 10; n++) begin
            send_vertex(mk_vertex(rand_coord(), rand_coord(), n % 3 == 2));
        end
        steady = 1'b0;
        hold_req <= 1'b0;
        end_burst();
    endtask

    task automatic test_random_contours;
        int sent;
        int len;
        sent = 0;
        while (sent < 1200) begin
            if ($urandom_range(0, 7) == 0) begin
                steady = ~steady;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                send_vertex(mk_vertex(rand_coord(), rand_coord(), k == len - 1));
            end
            sent += len;
        end
        steady = 1'b0;
        end_burst();
    endtask

    task automatic drain_results;
        int waited;
        waited = 0;
        while (pending_areas.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
            stall_pat <= '1;
            pat_age <= 0;
        end else begin
            if (pop && !empty) begin
                if (pending_areas.size() == 0) begin
                    $error("unexpected result: doubled_area %0d, is_hole %0b",
                           o_result.doubled_area, o_result.is_hole);
                    mismatches++;
                end else begin
                    if (o_result.doubled_area !== pending_areas[0].doubled_area) begin
                        $error("doubled_area: expected %0d, actual %0d",
                               pending_areas[0].doubled_area, o_result.doubled_area);
                        mismatches++;
                    end
                    if (o_result.is_hole !== pending_areas[0].is_hole) begin
                        $error("is_hole: expected %0b, actual %0b",
                               pending_areas[0].is_hole, o_result.is_hole);
                        mismatches++;
                    end
                    void'(pending_areas.pop_front());
                end
            end
            hold_seen <= hold_req;
            if (hold_req && !hold_seen) begin
                hold_left <= HOLD_LEN;
                pop <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= stall_pat[0];
                if (pat_age == 63) begin
                    pat_age <= 0;
                    case ($urandom_range(0, 3))
                        0: stall_pat <= '1;
                        1: stall_pat <= 16'($urandom);
                        2: stall_pat <= 16'($urandom | $urandom);
                        default: stall_pat <= 16'($urandom & $urandom);
                    endcase
                end else begin
                    pat_age <= pat_age + 1;
                    stall_pat <= {stall_pat[0], stall_pat[15:1]};
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_vertex();
        test_orientation();
        test_extreme_squares();
        test_long_winding();
        test_backpressure();
        test_random_contours();
        drain_results();
        if (pending_areas.size() != 0) begin
            $error("%0d expected results never arrived", pending_areas.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[polygon_orientation_classifier_core] OK");
        end else begin
            $display("[polygon_orientation_classifier_core] ERROR");
        end
        $finish;
    end

endmodule
